FILE: rtl/trle_pkg.sv
// Package for the TGA run-length pixel decoder.
// Holds the queue word type, the packet and register codes and the queue sizes.
// No dependencies.
package trle_pkg;

  // Packet header decode
  localparam logic [7:0] REPEAT_FLAG_MIN = 8'd128;
  localparam logic [7:0] REPEAT_BIAS     = 8'd127;

  // Pixel size selection
  localparam logic [2:0] BPP_FOUR = 3'd4;
  localparam logic [2:0] BPP_RESET = 3'd3;
  localparam logic [31:0] TOTAL_RESET = 32'd1;

  // Last byte position of a pixel
  localparam logic [1:0] LAST_POS_THREE = 2'd2;
  localparam logic [1:0] LAST_POS_FOUR  = 2'd3;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_TOTAL     = 1'b1;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // One classified byte: either a pixel's closing byte with its colour and
  // packet run, or any other byte that only takes part in the completion check
  typedef struct packed {
    logic       final_byte;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] run;
  } item_t;

endpackage

FILE: rtl/trle_if.sv
// Handshake channels of the TGA run-length pixel decoder.
// Byte input, pixel output and configuration write; uses trle_pkg.
interface trle_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface trle_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic [7:0] run_length;
  logic       last_pixel;

  modport source (output valid, output red, output green, output blue, output alpha,
                  output run_length, output last_pixel, input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  input run_length, input last_pixel, output ready);
endinterface

interface trle_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [trle_pkg::CFG_IDX_W-1:0] index;
  logic [31:0]                   wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

FILE: rtl/trle_front.sv
// Front end: takes bytes, tracks packet headers and byte position, assembles
// colour and pushes one classified word per byte into the queue. Uses trle_pkg.
module trle_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                four_byte,
  trle_byte_if.sink           data,
  input  logic                queue_ready,
  output logic                push,
  output trle_pkg::item_t     push_item
);

  logic        awaiting_header;
  logic        repeat_packet;
  logic [7:0]  packet_pixels_left;
  logic [1:0]  byte_in_pixel;
  logic [23:0] colour_buffer;

  logic        accept;
  logic        final_byte;
  logic [1:0]  last_pos;
  logic [7:0]  left_dec;
  logic [7:0]  b;

  assign b          = data.data_byte;
  assign data.ready = queue_ready;
  assign accept     = data.valid & queue_ready;
  assign push       = accept;

  assign last_pos   = four_byte ? trle_pkg::LAST_POS_FOUR : trle_pkg::LAST_POS_THREE;
  assign final_byte = !awaiting_header && (byte_in_pixel >= last_pos);
  assign left_dec   = (packet_pixels_left != 8'd0) ? packet_pixels_left - 8'd1
                                                   : packet_pixels_left;

  always_comb begin
    push_item.final_byte = final_byte;
    push_item.blue       = colour_buffer[7:0];
    push_item.green      = colour_buffer[15:8];
    push_item.red        = four_byte ? colour_buffer[23:16] : b;
    push_item.alpha      = four_byte ? b : 8'd0;
    push_item.run        = (repeat_packet && packet_pixels_left != 8'd0) ?
                           packet_pixels_left : 8'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_header    <= 1'b1;
      repeat_packet      <= 1'b0;
      packet_pixels_left <= 8'd0;
      byte_in_pixel      <= 2'd0;
      colour_buffer      <= 24'd0;
    end else if (accept) begin
      if (awaiting_header) begin
        if (b >= trle_pkg::REPEAT_FLAG_MIN) begin
          repeat_packet      <= 1'b1;
          packet_pixels_left <= b - trle_pkg::REPEAT_BIAS;
        end else begin
          repeat_packet      <= 1'b0;
          packet_pixels_left <= b + 8'd1;
        end
        awaiting_header <= 1'b0;
        byte_in_pixel   <= 2'd0;
      end else if (!final_byte) begin
        case (byte_in_pixel)
          2'd0:    colour_buffer[7:0]   <= b;
          2'd1:    colour_buffer[15:8]  <= b;
          default: colour_buffer[23:16] <= b;
        endcase
        byte_in_pixel <= byte_in_pixel + 2'd1;
      end else begin
        byte_in_pixel <= 2'd0;
        if (repeat_packet) begin
          packet_pixels_left <= 8'd0;
          awaiting_header    <= 1'b1;
        end else begin
          packet_pixels_left <= left_dec;
          awaiting_header    <= (left_dec == 8'd0);
        end
      end
    end
  end

endmodule

FILE: rtl/trle_queue.sv
// Two-word queue between the front and back ends.
// Holds trle_pkg::item_t words; uses trle_pkg.
module trle_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  trle_pkg::item_t push_item,
  output logic            push_ready,
  input  logic            pop,
  output logic            pop_valid,
  output trle_pkg::item_t pop_item
);

  trle_pkg::item_t                 slots [trle_pkg::QUEUE_DEPTH];
  logic [trle_pkg::QUEUE_AW-1:0]   wr_ptr;
  logic [trle_pkg::QUEUE_AW-1:0]   rd_ptr;
  logic [trle_pkg::QUEUE_CW-1:0]   count;
  logic                            do_push;
  logic                            do_pop;

  assign push_ready = (count != trle_pkg::QUEUE_CW'(trle_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push & push_ready;
  assign do_pop     = pop & pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == trle_pkg::QUEUE_AW'(trle_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == trle_pkg::QUEUE_AW'(trle_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + trle_pkg::QUEUE_CW'(1);
        2'b01:   count <= count - trle_pkg::QUEUE_CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/trle_back.sv
// Back end: counts pixels against the total, clamps runs, flags the last pixel
// and holds the output register. Uses trle_pkg and trle_pixel_if.
module trle_back (
  input  logic            clk,
  input  logic            rst,
  input  logic [31:0]     pixel_total,
  input  logic            queue_valid,
  input  trle_pkg::item_t queue_item,
  output logic            pop,
  trle_pixel_if.source    pixel
);

  logic [31:0] pixels_done;
  logic        image_complete;

  logic [31:0] remaining;
  logic        over;
  logic        drop;
  logic        emits;
  logic        out_free;
  logic        run_clamp;
  logic [7:0]  run_eff;

  assign remaining = pixel_total - pixels_done;
  assign over      = (pixels_done >= pixel_total);
  assign drop      = image_complete | over;
  assign emits     = !drop && queue_item.final_byte;
  assign out_free  = !pixel.valid || pixel.ready;
  assign pop       = queue_valid && (!emits || out_free);

  // run is at most 128, so a clamped run fits in 8 bits
  assign run_clamp = ({24'd0, queue_item.run} >= remaining);
  assign run_eff   = run_clamp ? remaining[7:0] : queue_item.run;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixels_done    <= 32'd0;
      image_complete <= 1'b0;
    end else if (pop) begin
      if (drop) begin
        image_complete <= 1'b1;
      end else if (queue_item.final_byte) begin
        pixels_done <= pixels_done + {24'd0, run_eff};
        if (run_clamp) begin
          image_complete <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel.valid <= 1'b0;
    end else if (pop && emits) begin
      pixel.valid <= 1'b1;
    end else if (pixel.ready) begin
      pixel.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emits) begin
      pixel.red        <= queue_item.red;
      pixel.green      <= queue_item.green;
      pixel.blue       <= queue_item.blue;
      pixel.alpha      <= queue_item.alpha;
      pixel.run_length <= run_eff;
      pixel.last_pixel <= run_clamp;
    end
  end

endmodule

FILE: rtl/tga_rle_pixel_decoder.sv
// Top level of the TGA run-length pixel decoder: configuration registers,
// front end, queue and back end. Uses trle_pkg, trle_if, trle_front,
// trle_queue and trle_back.
//
//   channel  dir  payload                                      handshake
//   data     in   data_byte[7:0]                               valid/ready
//   pixel    out  red, green, blue, alpha, run_length, last    valid/ready
//   cfg      in   index[0], wdata[31:0]                        valid/ready
//
// One byte a cycle when the pixel side keeps up; a pixel's closing byte passes
// through a queue slot and then the output register before the pixel leaves.
// The two-word queue lets the front keep taking bytes while a pixel waits.
// Reset (rst, synchronous) restores 3-byte pixels, a total of one and an
// empty packet state. cfg is always ready.
module tga_rle_pixel_decoder (
  input  logic          clk,
  input  logic          rst,
  trle_byte_if.sink     data,
  trle_pixel_if.source  pixel,
  trle_cfg_if.sink      cfg
);

  logic [2:0]      bytes_per_pixel;
  logic [31:0]     pixel_total;
  logic            four_byte;

  logic            push;
  trle_pkg::item_t push_item;
  logic            queue_ready;
  logic            pop;
  logic            queue_valid;
  trle_pkg::item_t queue_item;

  assign cfg.ready = 1'b1;
  assign four_byte = (bytes_per_pixel == trle_pkg::BPP_FOUR);

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel <= trle_pkg::BPP_RESET;
      pixel_total     <= trle_pkg::TOTAL_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        trle_pkg::CFG_BYTES_PER_PIXEL: bytes_per_pixel <= cfg.wdata[2:0];
        trle_pkg::CFG_PIXEL_TOTAL:     pixel_total     <= cfg.wdata;
        default: ;
      endcase
    end
  end

  trle_front u_front (
    .clk         (clk),
    .rst         (rst),
    .four_byte   (four_byte),
    .data        (data),
    .queue_ready (queue_ready),
    .push        (push),
    .push_item   (push_item)
  );

  trle_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .push_ready (queue_ready),
    .pop        (pop),
    .pop_valid  (queue_valid),
    .pop_item   (queue_item)
  );

  trle_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pixel_total (pixel_total),
    .queue_valid (queue_valid),
    .queue_item  (queue_item),
    .pop         (pop),
    .pixel       (pixel)
  );

endmodule

FILE: rtl/trle_checker.sv
// Port-level checks for the TGA run-length pixel decoder.
// Watches the pixel and cfg channels; bound to tga_rle_pixel_decoder below.
module trle_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic        cfg_index,
  input logic [2:0]  cfg_bpp,
  input logic        pixel_valid,
  input logic        pixel_ready,
  input logic [7:0]  pixel_alpha,
  input logic [7:0]  pixel_run_length,
  input logic        pixel_last
);

  logic       seen_last;
  logic [2:0] bpp_copy;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_last <= 1'b0;
      bpp_copy  <= trle_pkg::BPP_RESET;
    end else begin
      if (pixel_valid && pixel_ready && pixel_last) begin
        seen_last <= 1'b1;
      end
      if (cfg_valid && cfg_ready && cfg_index == trle_pkg::CFG_BYTES_PER_PIXEL) begin
        bpp_copy <= cfg_bpp;
      end
    end
  end

  a_run_range: assert property (@(posedge clk) disable iff (rst)
    pixel_valid |-> (pixel_run_length != 8'd0 && pixel_run_length <= 8'd128))
    else $error("run length out of range");

  a_none_after_last: assert property (@(posedge clk) disable iff (rst)
    pixel_valid |-> !seen_last)
    else $error("word after the last pixel");

  a_alpha_three: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && bpp_copy != trle_pkg::BPP_FOUR) |-> pixel_alpha == 8'd0)
    else $error("nonzero alpha with 3-byte pixels");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && !pixel_ready) |=>
      (pixel_valid && $stable(pixel_run_length) && $stable(pixel_last)))
    else $error("stalled pixel word changed");

endmodule

bind tga_rle_pixel_decoder trle_checker u_trle_checker (
  .clk              (clk),
  .rst              (rst),
  .cfg_valid        (cfg.valid),
  .cfg_ready        (cfg.ready),
  .cfg_index        (cfg.index),
  .cfg_bpp          (cfg.wdata[2:0]),
  .pixel_valid      (pixel.valid),
  .pixel_ready      (pixel.ready),
  .pixel_alpha      (pixel.alpha),
  .pixel_run_length (pixel.run_length),
  .pixel_last       (pixel.last_pixel)
);
